// ===== rtl/lsrk_pkg.sv =====
// shared types and constants for the longest repeated substring block
`default_nettype none
package lsrk_pkg;

    localparam int SYM_BITS = 16;
    localparam int RES_BITS = 15;

    typedef struct packed {
        logic [SYM_BITS-1:0] symbol;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [RES_BITS-1:0] repeat_length;
        logic                overflow;
    } result_t;

    typedef enum logic [1:0] {
        PK_SYM,
        PK_SEC,
        PK_FIRST
    } pass_t;

    typedef enum logic [4:0] {
        ES_IDLE,
        ES_CLR,
        ES_CNT_RD,
        ES_CNT_BK,
        ES_CNT_WR,
        ES_PFX_RD,
        ES_PFX_WR,
        ES_SC_RD,
        ES_SC_KEY,
        ES_SC_BK,
        ES_SC_WR,
        ES_RR_RD,
        ES_RR_KEY,
        ES_RR_WR,
        ES_KY_RD,
        ES_KY_K1,
        ES_KY_K2,
        ES_LC_RK,
        ES_LC_SA,
        ES_LC_J,
        ES_LC_TA,
        ES_LC_TB,
        ES_LC_CMP,
        ES_LC_WR,
        ES_WN_RD,
        ES_WN_V,
        ES_WN_TL,
        ES_WN_CMP,
        ES_WN_PUSH,
        ES_WN_HD,
        ES_WN_CHK,
        ES_DONE
    } eng_state_t;

endpackage
`default_nettype wire

// ===== rtl/longest_substring_repeated_k_times_top.sv =====
// top level: symbol loading, configuration register and result strobe
//
// usage
//   symbols arrive on item (symbol, last); a beat is taken at a clock edge
//   with start high and busy low, one symbol per cycle while loading
//   the beat with last set starts the search; busy stays high until the
//   result has been produced, then result_valid pulses for one cycle with
//   repeat_length and overflow; the receiver cannot stall this strobe
//   min_occurrences is written through cfg_valid/cfg_ready/cfg_data and is
//   taken only while busy is low; it resets to 2
//   symbols beyond MAX_LEN are dropped and flag overflow in the result
// search, after the edge that takes the last beat
//   min_occurrences of 0 or 1, or above the length: no search is made
//   otherwise, all state in synchronous memories: a first sort over
//   65536 symbol buckets, then each doubling round, the height walk,
//   the sliding window pass, and then the strobe
// reset
//   asynchronous, active low; clears the length, overflow flag and busy
`default_nettype none
module longest_substring_repeated_k_times_top
    import lsrk_pkg::*;
#(
    parameter int MAX_LEN = 16384
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire item_t               item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [RES_BITS-1:0] cfg_data,
    output logic                     result_valid,
    output result_t                  result
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int IW = $clog2(MAX_LEN + 1);

    logic [IW-1:0]       len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic                busy_reg, busy_next;
    logic [RES_BITS-1:0] k_reg, k_next;
    logic                rv_reg, rv_next;
    result_t             res_reg, res_next;

    logic                accept, full, go, done;
    logic [RES_BITS-1:0] eng_res;

    assign accept = start && !busy_reg;
    assign full   = (len_reg == IW'(MAX_LEN));
    // the final beat starts the engine with the updated length
    assign go     = accept && item.last;

    always_comb
    begin
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        busy_next = busy_reg;
        k_next    = k_reg;
        rv_next   = 1'b0;
        res_next  = res_reg;
        if (accept)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + 1'b1;
            end
            if (item.last)
            begin
                busy_next = 1'b1;
            end
        end
        if (cfg_valid && cfg_ready)
        begin
            k_next = cfg_data;
        end
        if (done)
        begin
            rv_next                = 1'b1;
            res_next.repeat_length = eng_res;
            res_next.overflow      = ovf_reg;
            len_next               = '0;
            ovf_next               = 1'b0;
            busy_next              = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            busy_reg <= 1'b0;
            k_reg    <= RES_BITS'(2);
            rv_reg   <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            busy_reg <= busy_next;
            k_reg    <= k_next;
            rv_reg   <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    lsrk_engine #(
        .MAX_LEN (MAX_LEN)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .txt_we (accept && !full),
        .txt_wa (len_reg[AW-1:0]),
        .txt_wd (item.symbol),
        .go     (go),
        .len    (len_next),
        .k_in   (k_reg),
        .done   (done),
        .res    (eng_res)
    );

    assign busy         = busy_reg;
    assign cfg_ready    = !busy_reg;
    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire

// ===== rtl/lsrk_engine.sv =====
// suffix array, lcp and sliding window engine over its working memories
`default_nettype none
module lsrk_engine
    import lsrk_pkg::*;
#(
    parameter int MAX_LEN = 16384
)
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      txt_we,
    input  wire logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] txt_wa,
    input  wire logic [SYM_BITS-1:0]                       txt_wd,
    input  wire logic                                      go,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]              len,
    input  wire logic [RES_BITS-1:0]                       k_in,
    output logic                                           done,
    output logic [RES_BITS-1:0]                            res
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int IW = $clog2(MAX_LEN + 1);
    localparam int SYM_COUNT = 2 ** SYM_BITS;
    localparam int CNT_DEPTH = (SYM_COUNT > MAX_LEN + 1) ? SYM_COUNT : MAX_LEN + 1;
    localparam int CAW = $clog2(CNT_DEPTH);
    localparam int KW = (IW > RES_BITS) ? IW : RES_BITS;
    localparam int DW = AW + IW;

    // memories
    logic [SYM_BITS-1:0] txt_mem [MAX_LEN];
    logic [AW-1:0]       sa_mem  [MAX_LEN];
    logic [AW-1:0]       sk_mem  [MAX_LEN];
    logic [IW-1:0]       rk_mem  [MAX_LEN];
    logic [IW-1:0]       k1_mem  [MAX_LEN];
    logic [IW-1:0]       k2_mem  [MAX_LEN];
    logic [IW-1:0]       cnt_mem [CNT_DEPTH];
    logic [IW-1:0]       lcp_mem [MAX_LEN];
    logic [DW-1:0]       dq_mem  [MAX_LEN];

    logic [SYM_BITS-1:0] txt_rd;
    logic [AW-1:0]       sa_rd, sk_rd;
    logic [IW-1:0]       rk_rd, k1_rd, k2_rd, cnt_rd, lcp_rd;
    logic [DW-1:0]       dq_rd;

    logic [AW-1:0]  txt_ra, sa_ra, sk_ra, rk_ra, k1_ra, k2_ra, lcp_ra, dq_ra;
    logic [CAW-1:0] cnt_ra;
    logic           sa_we, sk_we, rk_we, k1_we, k2_we, cnt_we, lcp_we, dq_we;
    logic [AW-1:0]  sa_wa, sk_wa, rk_wa, k1_wa, k2_wa, lcp_wa, dq_wa;
    logic [CAW-1:0] cnt_wa;
    logic [AW-1:0]  sa_wd, sk_wd;
    logic [IW-1:0]  rk_wd, k1_wd, k2_wd, cnt_wd, lcp_wd;
    logic [DW-1:0]  dq_wd;

    always_ff @(posedge clk)
    begin
        if (txt_we)
        begin
            txt_mem[txt_wa] <= txt_wd;
        end
        txt_rd <= txt_mem[txt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sa_we)
        begin
            sa_mem[sa_wa] <= sa_wd;
        end
        sa_rd <= sa_mem[sa_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sk_we)
        begin
            sk_mem[sk_wa] <= sk_wd;
        end
        sk_rd <= sk_mem[sk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[rk_wa] <= rk_wd;
        end
        rk_rd <= rk_mem[rk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (k1_we)
        begin
            k1_mem[k1_wa] <= k1_wd;
        end
        k1_rd <= k1_mem[k1_ra];
    end

    always_ff @(posedge clk)
    begin
        if (k2_we)
        begin
            k2_mem[k2_wa] <= k2_wd;
        end
        k2_rd <= k2_mem[k2_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (lcp_we)
        begin
            lcp_mem[lcp_wa] <= lcp_wd;
        end
        lcp_rd <= lcp_mem[lcp_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dq_we)
        begin
            dq_mem[dq_wa] <= dq_wd;
        end
        dq_rd <= dq_mem[dq_ra];
    end

    // sequencer registers
    eng_state_t          state_reg, state_next;
    pass_t               kind_reg, kind_next;
    logic                first_reg, first_next;
    logic                xdone_reg, xdone_next;
    logic [AW-1:0]       i_reg, i_next;
    logic [CAW-1:0]      ci_reg, ci_next;
    logic [CAW-1:0]      bnd_reg, bnd_next;
    logic [IW-1:0]       acc_reg, acc_next;
    logic [CAW-1:0]      key_reg, key_next;
    logic [AW-1:0]       p_reg, p_next;
    logic [IW-1:0]       r_reg, r_next;
    logic [SYM_BITS-1:0] pt_reg, pt_next;
    logic [IW-1:0]       pk1_reg, pk1_next;
    logic [IW-1:0]       pk2_reg, pk2_next;
    logic [IW:0]         l_reg, l_next;
    logic [IW-1:0]       h_reg, h_next;
    logic [IW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       j_reg, j_next;
    logic [SYM_BITS-1:0] t_reg, t_next;
    logic [IW-1:0]       v_reg, v_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic [IW-1:0]       w_reg, w_next;
    logic [IW-1:0]       best_reg, best_next;
    logic [IW-1:0]       n_reg, n_next;
    logic [RES_BITS-1:0] res_reg, res_next;

    logic [CAW-1:0] key_d;
    logic [AW-1:0]  psel;
    logic           i_last;
    logic [IW:0]    il_sum, ih_sum, jh_sum, n_ext, exp_sum;
    logic           rr_diff;
    logic [IW-1:0]  r_new;
    logic [IW:0]    l_new;
    logic [IW-1:0]  pfx_sum, cnt_dec, best_new;
    logic [AW-1:0]  dq_idx;
    logic [IW-1:0]  dq_v;

    always_comb
    begin
        case (kind_reg)
            PK_SYM:  key_d = CAW'(txt_rd);
            PK_SEC:  key_d = CAW'(k2_rd);
            default: key_d = CAW'(k1_rd);
        endcase
    end

    assign psel    = (kind_reg == PK_FIRST) ? sk_rd : i_reg;
    assign i_last  = (IW'(i_reg) == n_reg - 1'b1);
    assign n_ext   = (IW+1)'(n_reg);
    assign il_sum  = (IW+1)'(i_reg) + l_reg;
    assign ih_sum  = (IW+1)'(i_reg) + (IW+1)'(h_reg);
    assign jh_sum  = (IW+1)'(j_reg) + (IW+1)'(h_reg);
    assign rr_diff = (i_reg == '0) ? 1'b1 :
                     first_reg ? (txt_rd != pt_reg) :
                     ((k1_rd != pk1_reg) || (k2_rd != pk2_reg));
    assign r_new   = r_reg + IW'(rr_diff);
    assign l_new   = first_reg ? (IW+1)'(1) : (l_reg << 1);
    assign pfx_sum = acc_reg + cnt_rd;
    assign cnt_dec = cnt_rd - 1'b1;
    assign dq_idx  = dq_rd[DW-1:IW];
    assign dq_v    = dq_rd[IW-1:0];
    assign exp_sum = (IW+1)'(dq_idx) + (IW+1)'(w_reg);
    assign best_new = ((IW'(i_reg) >= w_reg) && (dq_v > best_reg)) ? dq_v : best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ES_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        first_reg <= first_next;
        xdone_reg <= xdone_next;
        i_reg     <= i_next;
        ci_reg    <= ci_next;
        bnd_reg   <= bnd_next;
        acc_reg   <= acc_next;
        key_reg   <= key_next;
        p_reg     <= p_next;
        r_reg     <= r_next;
        pt_reg    <= pt_next;
        pk1_reg   <= pk1_next;
        pk2_reg   <= pk2_next;
        l_reg     <= l_next;
        h_reg     <= h_next;
        pos_reg   <= pos_next;
        j_reg     <= j_next;
        t_reg     <= t_next;
        v_reg     <= v_next;
        head_reg  <= head_next;
        tail_reg  <= tail_next;
        w_reg     <= w_next;
        best_reg  <= best_next;
        n_reg     <= n_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        first_next = first_reg;
        xdone_next = xdone_reg;
        i_next     = i_reg;
        ci_next    = ci_reg;
        bnd_next   = bnd_reg;
        acc_next   = acc_reg;
        key_next   = key_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        pt_next    = pt_reg;
        pk1_next   = pk1_reg;
        pk2_next   = pk2_reg;
        l_next     = l_reg;
        h_next     = h_reg;
        pos_next   = pos_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        v_next     = v_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        w_next     = w_reg;
        best_next  = best_reg;
        n_next     = n_reg;
        res_next   = res_reg;

        txt_ra = i_reg;
        sa_ra  = i_reg;
        sk_ra  = i_reg;
        rk_ra  = i_reg;
        k1_ra  = i_reg;
        k2_ra  = i_reg;
        lcp_ra = i_reg;
        dq_ra  = head_reg[AW-1:0];
        cnt_ra = ci_reg;
        sa_we  = 1'b0;
        sk_we  = 1'b0;
        rk_we  = 1'b0;
        k1_we  = 1'b0;
        k2_we  = 1'b0;
        cnt_we = 1'b0;
        lcp_we = 1'b0;
        dq_we  = 1'b0;
        sa_wa  = cnt_dec[AW-1:0];
        sk_wa  = cnt_dec[AW-1:0];
        rk_wa  = p_reg;
        k1_wa  = i_reg;
        k2_wa  = i_reg;
        cnt_wa = ci_reg;
        lcp_wa = pos_reg[AW-1:0];
        dq_wa  = tail_reg[AW-1:0];
        sa_wd  = p_reg;
        sk_wd  = p_reg;
        rk_wd  = r_new;
        k1_wd  = rk_rd;
        k2_wd  = rk_rd;
        cnt_wd = '0;
        lcp_wd = h_reg;
        dq_wd  = {i_reg, v_reg};
        done   = 1'b0;

        case (state_reg)
            ES_IDLE:
            begin
                if (go)
                begin
                    n_next = len;
                    w_next = IW'(k_in - 1'b1);
                    if (KW'(k_in) <= KW'(1))
                    begin
                        res_next   = RES_BITS'(len);
                        state_next = ES_DONE;
                    end
                    else if (KW'(k_in) > KW'(len))
                    begin
                        res_next   = '0;
                        state_next = ES_DONE;
                    end
                    else
                    begin
                        kind_next  = PK_SYM;
                        ci_next    = '0;
                        bnd_next   = CAW'(SYM_COUNT - 1);
                        state_next = ES_CLR;
                    end
                end
            end
            // clear the buckets of this counting pass
            ES_CLR:
            begin
                cnt_we = 1'b1;
                cnt_wa = ci_reg;
                cnt_wd = '0;
                if (ci_reg == bnd_reg)
                begin
                    i_next     = '0;
                    state_next = ES_CNT_RD;
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                end
            end
            ES_CNT_RD:
            begin
                state_next = ES_CNT_BK;
            end
            ES_CNT_BK:
            begin
                key_next   = key_d;
                cnt_ra     = key_d;
                state_next = ES_CNT_WR;
            end
            ES_CNT_WR:
            begin
                cnt_we = 1'b1;
                cnt_wa = key_reg;
                cnt_wd = cnt_rd + 1'b1;
                if (i_last)
                begin
                    ci_next    = '0;
                    acc_next   = '0;
                    state_next = ES_PFX_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ES_CNT_RD;
                end
            end
            ES_PFX_RD:
            begin
                state_next = ES_PFX_WR;
            end
            ES_PFX_WR:
            begin
                cnt_we   = 1'b1;
                cnt_wa   = ci_reg;
                cnt_wd   = pfx_sum;
                acc_next = pfx_sum;
                if (ci_reg == bnd_reg)
                begin
                    i_next     = AW'(n_reg - 1'b1);
                    state_next = ES_SC_RD;
                end
                else
                begin
                    ci_next    = ci_reg + 1'b1;
                    state_next = ES_PFX_RD;
                end
            end
            // scatter from the top down
            ES_SC_RD:
            begin
                state_next = ES_SC_KEY;
            end
            ES_SC_KEY:
            begin
                p_next     = psel;
                txt_ra     = psel;
                k1_ra      = psel;
                k2_ra      = psel;
                state_next = ES_SC_BK;
            end
            ES_SC_BK:
            begin
                key_next   = key_d;
                cnt_ra     = key_d;
                state_next = ES_SC_WR;
            end
            ES_SC_WR:
            begin
                cnt_we = 1'b1;
                cnt_wa = key_reg;
                cnt_wd = cnt_dec;
                if (kind_reg == PK_SEC)
                begin
                    sk_we = 1'b1;
                end
                else
                begin
                    sa_we = 1'b1;
                end
                if (i_reg == '0)
                begin
                    case (kind_reg)
                        PK_SEC:
                        begin
                            kind_next  = PK_FIRST;
                            ci_next    = '0;
                            state_next = ES_CLR;
                        end
                        PK_SYM:
                        begin
                            first_next = 1'b1;
                            r_next     = '0;
                            state_next = ES_RR_RD;
                        end
                        default:
                        begin
                            first_next = 1'b0;
                            r_next     = '0;
                            state_next = ES_RR_RD;
                        end
                    endcase
                end
                else
                begin
                    i_next     = i_reg - 1'b1;
                    state_next = ES_SC_RD;
                end
            end
            // new ranks in sorted order
            ES_RR_RD:
            begin
                state_next = ES_RR_KEY;
            end
            ES_RR_KEY:
            begin
                p_next     = sa_rd;
                txt_ra     = sa_rd;
                k1_ra      = sa_rd;
                k2_ra      = sa_rd;
                state_next = ES_RR_WR;
            end
            ES_RR_WR:
            begin
                rk_we    = 1'b1;
                r_next   = r_new;
                pt_next  = txt_rd;
                pk1_next = k1_rd;
                pk2_next = k2_rd;
                if (i_last)
                begin
                    l_next = l_new;
                    i_next = '0;
                    h_next = '0;
                    if ((r_new < n_reg) && (l_new < n_ext))
                    begin
                        state_next = ES_KY_RD;
                    end
                    else
                    begin
                        state_next = ES_LC_RK;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ES_RR_RD;
                end
            end
            // key pair for the next doubling round
            ES_KY_RD:
            begin
                state_next = ES_KY_K1;
            end
            ES_KY_K1:
            begin
                k1_we      = 1'b1;
                k1_wd      = rk_rd;
                rk_ra      = il_sum[AW-1:0];
                state_next = ES_KY_K2;
            end
            ES_KY_K2:
            begin
                k2_we = 1'b1;
                k2_wd = (il_sum < n_ext) ? rk_rd : '0;
                if (i_last)
                begin
                    kind_next  = PK_SEC;
                    ci_next    = '0;
                    bnd_next   = CAW'(n_reg);
                    state_next = ES_CLR;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ES_KY_RD;
                end
            end
            // height walk in text order
            ES_LC_RK:
            begin
                state_next = ES_LC_SA;
            end
            ES_LC_SA:
            begin
                pos_next = rk_rd - 1'b1;
                sa_ra    = AW'(rk_rd - 2'd2);
                if (rk_rd == IW'(1))
                begin
                    h_next = '0;
                    if (i_last)
                    begin
                        i_next     = AW'(1);
                        head_next  = '0;
                        tail_next  = '0;
                        best_next  = '0;
                        state_next = ES_WN_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ES_LC_RK;
                    end
                end
                else
                begin
                    state_next = ES_LC_J;
                end
            end
            ES_LC_J:
            begin
                j_next     = sa_rd;
                state_next = ES_LC_TA;
            end
            ES_LC_TA:
            begin
                txt_ra = ih_sum[AW-1:0];
                if ((ih_sum < n_ext) && (jh_sum < n_ext))
                begin
                    state_next = ES_LC_TB;
                end
                else
                begin
                    state_next = ES_LC_WR;
                end
            end
            ES_LC_TB:
            begin
                t_next     = txt_rd;
                txt_ra     = jh_sum[AW-1:0];
                state_next = ES_LC_CMP;
            end
            ES_LC_CMP:
            begin
                if (txt_rd == t_reg)
                begin
                    h_next     = h_reg + 1'b1;
                    state_next = ES_LC_TA;
                end
                else
                begin
                    state_next = ES_LC_WR;
                end
            end
            ES_LC_WR:
            begin
                lcp_we = 1'b1;
                h_next = (h_reg != '0) ? h_reg - 1'b1 : '0;
                if (i_last)
                begin
                    i_next     = AW'(1);
                    head_next  = '0;
                    tail_next  = '0;
                    best_next  = '0;
                    state_next = ES_WN_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ES_LC_RK;
                end
            end
            // sliding window minimum, deque holds index and height
            ES_WN_RD:
            begin
                state_next = ES_WN_V;
            end
            ES_WN_V:
            begin
                v_next     = lcp_rd;
                state_next = ES_WN_TL;
            end
            ES_WN_TL:
            begin
                dq_ra = AW'(tail_reg - 1'b1);
                if (tail_reg > head_reg)
                begin
                    state_next = ES_WN_CMP;
                end
                else
                begin
                    state_next = ES_WN_PUSH;
                end
            end
            ES_WN_CMP:
            begin
                if (dq_v >= v_reg)
                begin
                    tail_next  = tail_reg - 1'b1;
                    state_next = ES_WN_TL;
                end
                else
                begin
                    state_next = ES_WN_PUSH;
                end
            end
            ES_WN_PUSH:
            begin
                dq_we      = 1'b1;
                tail_next  = tail_reg + 1'b1;
                xdone_next = 1'b0;
                state_next = ES_WN_HD;
            end
            ES_WN_HD:
            begin
                state_next = ES_WN_CHK;
            end
            ES_WN_CHK:
            begin
                if (!xdone_reg && (exp_sum <= (IW+1)'(i_reg)))
                begin
                    head_next  = head_reg + 1'b1;
                    xdone_next = 1'b1;
                    state_next = ES_WN_HD;
                end
                else
                begin
                    best_next = best_new;
                    if (i_last)
                    begin
                        res_next   = RES_BITS'(best_new);
                        state_next = ES_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ES_WN_RD;
                    end
                end
            end
            ES_DONE:
            begin
                done       = 1'b1;
                state_next = ES_IDLE;
            end
            default:
            begin
                state_next = ES_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule
`default_nettype wire
